@@ rtl/core/dencxy_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dencxy_pkg: shared types and constants of the dual encoder CoreXY block
// Field widths, motion classes and the queue entry that travels from the
// unwrap front end to the position back end.
// ----------------------------------------------------------------------------
package dencxy_pkg;

  localparam int ANGLE_BITS    = 12;
  localparam int TURN_BITS     = 24;
  localparam int TOTAL_BITS    = 36;
  localparam int POS_BITS      = 48;
  localparam int RECIP_BITS    = 24;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 224;

  localparam logic [RECIP_BITS-1:0] RECIP_RESET = 24'd65574;

  typedef enum logic [2:0] {
    MOTION_STILL     = 3'd0,
    MOTION_RISING    = 3'd1,
    MOTION_FALLING   = 3'd2,
    MOTION_WRAP_UP   = 3'd3,
    MOTION_WRAP_DOWN = 3'd4
  } motion_t;

  typedef struct packed {
    logic signed [TOTAL_BITS-1:0] total_a;
    logic signed [TOTAL_BITS-1:0] total_b;
    logic signed [TURN_BITS-1:0]  turns_a;
    logic signed [TURN_BITS-1:0]  turns_b;
    motion_t                      motion_a;
    motion_t                      motion_b;
  } entry_t;

endpackage

@@ rtl/core/dencxy_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dencxy_front: angle unwrap front end
// Accepts angle pairs, primes on the first pair, tracks turns per encoder
// and pushes totals, turns and motion classes into the queue.
// ----------------------------------------------------------------------------
module dencxy_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dencxy_pkg::IN_DATA_BITS-1:0]   in_data,
  output logic                                  q_push,
  output dencxy_pkg::entry_t                    q_entry,
  input  logic                                  q_full
);

  localparam int AB   = dencxy_pkg::ANGLE_BITS;
  localparam int TB   = dencxy_pkg::TURN_BITS;
  localparam int OB   = dencxy_pkg::TOTAL_BITS;
  localparam int WW   = TB + AB + 1;
  localparam int HALF = 1 << (AB - 1);

  localparam logic signed [TB-1:0] TURN_MAX = {1'b0, {(TB-1){1'b1}}};
  localparam logic signed [TB-1:0] TURN_MIN = {1'b1, {(TB-1){1'b0}}};
  localparam logic signed [WW-1:0] W_TOT_MAX = {{(WW-OB+1){1'b0}}, {(OB-1){1'b1}}};
  localparam logic signed [WW-1:0] W_TOT_MIN = {{(WW-OB+1){1'b1}}, {(OB-1){1'b0}}};

  logic          primed;
  logic [AB-1:0] prev_a, prev_b, origin_a, origin_b;
  logic signed [TB-1:0] turns_a, turns_b;

  logic          accept;
  logic [AB-1:0] angle_a, angle_b;
  dencxy_pkg::motion_t  mot_a, mot_b;
  logic signed [TB-1:0] turns_a_next, turns_b_next;

  function automatic dencxy_pkg::motion_t classify(input logic [AB-1:0] angle,
                                                   input logic [AB-1:0] prev);
    logic signed [AB:0] d;
    dencxy_pkg::motion_t m;
    d = $signed({1'b0, angle}) - $signed({1'b0, prev});
    if (d < -HALF)     m = dencxy_pkg::MOTION_WRAP_UP;
    else if (d > HALF) m = dencxy_pkg::MOTION_WRAP_DOWN;
    else if (d > 0)    m = dencxy_pkg::MOTION_RISING;
    else if (d < 0)    m = dencxy_pkg::MOTION_FALLING;
    else               m = dencxy_pkg::MOTION_STILL;
    return m;
  endfunction

  function automatic logic signed [TB-1:0] step_turns(input logic signed [TB-1:0] t,
                                                      input dencxy_pkg::motion_t m);
    logic signed [TB-1:0] r;
    r = t;
    if (m == dencxy_pkg::MOTION_WRAP_UP && t != TURN_MAX) r = t + TB'(1);
    if (m == dencxy_pkg::MOTION_WRAP_DOWN && t != TURN_MIN) r = t - TB'(1);
    return r;
  endfunction

  function automatic logic signed [OB-1:0] total(input logic signed [TB-1:0] t,
                                                 input logic [AB-1:0] angle,
                                                 input logic [AB-1:0] origin);
    logic signed [WW-1:0] w;
    logic signed [OB-1:0] r;
    w = $signed({t[TB-1], t, {AB{1'b0}}})
        + $signed({{(TB+1){1'b0}}, angle})
        - $signed({{(TB+1){1'b0}}, origin});
    if (w > W_TOT_MAX)      r = W_TOT_MAX[OB-1:0];
    else if (w < W_TOT_MIN) r = W_TOT_MIN[OB-1:0];
    else                    r = w[OB-1:0];
    return r;
  endfunction

  assign angle_a  = in_data[AB-1:0];
  assign angle_b  = in_data[2*AB-1:AB];
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && primed;

  always_comb begin
    mot_a        = classify(angle_a, prev_a);
    mot_b        = classify(angle_b, prev_b);
    turns_a_next = step_turns(turns_a, mot_a);
    turns_b_next = step_turns(turns_b, mot_b);
  end

  always_comb begin
    q_entry.total_a  = total(turns_a_next, angle_a, origin_a);
    q_entry.total_b  = total(turns_b_next, angle_b, origin_b);
    q_entry.turns_a  = turns_a_next;
    q_entry.turns_b  = turns_b_next;
    q_entry.motion_a = mot_a;
    q_entry.motion_b = mot_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed   <= 1'b0;
      prev_a   <= '0;
      prev_b   <= '0;
      origin_a <= '0;
      origin_b <= '0;
      turns_a  <= '0;
      turns_b  <= '0;
    end else if (accept) begin
      prev_a <= angle_a;
      prev_b <= angle_b;
      if (!primed) begin
        // The priming pair sets the origin and leaves the turn counts alone.
        primed   <= 1'b1;
        origin_a <= angle_a;
        origin_b <= angle_b;
      end else begin
        turns_a <= turns_a_next;
        turns_b <= turns_b_next;
      end
    end
  end

endmodule

@@ rtl/core/dencxy_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dencxy_fifo: queue between front end and back end
// Small register queue of unwrap results with full and valid flags.
// ----------------------------------------------------------------------------
module dencxy_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dencxy_pkg::entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output dencxy_pkg::entry_t pop_entry,
  output logic               valid
);

  localparam int PB = $clog2(DEPTH);
  localparam int CB = $clog2(DEPTH + 1);

  dencxy_pkg::entry_t mem [DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [CB-1:0] count;

  assign full      = (count == CB'(DEPTH));
  assign valid     = (count != '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(DEPTH - 1)) ? '0 : wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(DEPTH - 1)) ? '0 : rd_ptr + PB'(1);
      end
      if (push && !pop)      count <= count + CB'(1);
      else if (!push && pop) count <= count - CB'(1);
    end
  end

endmodule

@@ rtl/core/dencxy_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dencxy_back: CoreXY position back end
// Four-stage pipeline: channel sum and difference, split partial products
// with the reciprocal, product assembly, then rounding and saturation into
// the output register.
// ----------------------------------------------------------------------------
module dencxy_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  dencxy_pkg::entry_t                    q_entry,
  input  logic [dencxy_pkg::RECIP_BITS-1:0]     recip,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dencxy_pkg::OUT_DATA_BITS-1:0]  out_data
);

  localparam int OB   = dencxy_pkg::TOTAL_BITS;
  localparam int RB   = dencxy_pkg::RECIP_BITS;
  localparam int POSB = dencxy_pkg::POS_BITS;
  localparam int SW   = OB + 1;
  localparam int LO   = 18;
  localparam int HI   = SW - LO;
  localparam int LP   = LO + RB;
  localparam int HP   = HI + RB + 1;
  localparam int PW   = SW + RB + 1;
  localparam int NW   = PW + 1;
  localparam int QW   = NW - 8;
  localparam int PAD  = dencxy_pkg::OUT_DATA_BITS - 2 * OB - 2 * dencxy_pkg::TURN_BITS
                        - 6 - 2 * POSB;

  localparam logic signed [NW-1:0] ROUND_BIAS = NW'(128);
  localparam logic signed [QW-1:0] Q_POS_MAX = {{(QW-POSB+1){1'b0}}, {(POSB-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_POS_MIN = {{(QW-POSB+1){1'b1}}, {(POSB-1){1'b0}}};

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  dencxy_pkg::entry_t e1, e2, e3;
  logic signed [SW-1:0] sx1, sy1;
  logic [LP-1:0]        lox2, loy2;
  logic signed [HP-1:0] hix2, hiy2;
  logic signed [PW-1:0] px3, py3;

  logic signed [SW-1:0] sx_c, sy_c;
  logic [LP-1:0]        lox_c, loy_c;
  logic signed [HP-1:0] hix_c, hiy_c;
  logic signed [PW-1:0] px_c, py_c;
  logic signed [POSB-1:0] posx_c, posy_c;

  function automatic logic [LP-1:0] mul_lo(input logic signed [SW-1:0] s,
                                           input logic [RB-1:0] r);
    return {{RB{1'b0}}, s[LO-1:0]} * {{LO{1'b0}}, r};
  endfunction

  function automatic logic signed [HP-1:0] mul_hi(input logic signed [SW-1:0] s,
                                                  input logic [RB-1:0] r);
    return $signed({{(HP-HI){s[SW-1]}}, s[SW-1:LO]}) * $signed({{(HP-RB){1'b0}}, r});
  endfunction

  function automatic logic signed [PW-1:0] assemble(input logic signed [HP-1:0] h,
                                                    input logic [LP-1:0] l);
    return ($signed({{(PW-HP){h[HP-1]}}, h}) <<< LO) + $signed({{(PW-LP){1'b0}}, l});
  endfunction

  // Negate, add half an LSB and floor-shift: round to nearest, ties upward.
  function automatic logic signed [POSB-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [NW-1:0] n;
    logic signed [QW-1:0] q;
    logic signed [POSB-1:0] r;
    n = ROUND_BIAS - $signed({p[PW-1], p});
    q = n[NW-1:8];
    if (q > Q_POS_MAX)      r = Q_POS_MAX[POSB-1:0];
    else if (q < Q_POS_MIN) r = Q_POS_MIN[POSB-1:0];
    else                    r = q[POSB-1:0];
    return r;
  endfunction

  assign rdy4  = out_ready;
  assign rdy3  = !out_valid || rdy4;
  assign rdy2  = !v3 || rdy3;
  assign rdy1  = !v2 || rdy2;
  assign q_pop = q_valid && (!v1 || rdy1);

  always_comb begin
    sx_c   = $signed({q_entry.total_a[OB-1], q_entry.total_a})
             + $signed({q_entry.total_b[OB-1], q_entry.total_b});
    sy_c   = $signed({q_entry.total_a[OB-1], q_entry.total_a})
             - $signed({q_entry.total_b[OB-1], q_entry.total_b});
    lox_c  = mul_lo(sx1, recip);
    loy_c  = mul_lo(sy1, recip);
    hix_c  = mul_hi(sx1, recip);
    hiy_c  = mul_hi(sy1, recip);
    px_c   = assemble(hix2, lox2);
    py_c   = assemble(hiy2, loy2);
    posx_c = round_sat(px3);
    posy_c = round_sat(py3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!v1 || rdy1) v1 <= q_valid;
      if (rdy1)        v2 <= v1;
      if (rdy2)        v3 <= v2;
      if (rdy3)        out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!v1 || rdy1) begin
      e1  <= q_entry;
      sx1 <= sx_c;
      sy1 <= sy_c;
    end
    if (rdy1) begin
      e2   <= e1;
      lox2 <= lox_c;
      loy2 <= loy_c;
      hix2 <= hix_c;
      hiy2 <= hiy_c;
    end
    if (rdy2) begin
      e3  <= e2;
      px3 <= px_c;
      py3 <= py_c;
    end
    if (rdy3) begin
      out_data <= {{PAD{1'b0}}, posy_c, posx_c, e3.motion_b, e3.motion_a,
                   e3.turns_b, e3.turns_a, e3.total_b, e3.total_a};
    end
  end

endmodule

@@ rtl/core/dual_encoder_multiturn_corexy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_encoder_multiturn_corexy: two-encoder multiturn unwrap with CoreXY
// Unwraps two absolute 12-bit encoders into turn counts and totals and
// converts them to fixed-point CoreXY X and Y positions.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Contents
// s_axis    in         24     angle_a, angle_b
// m_axis    out        224    totals, turns, motion classes, pos_x, pos_y
// cfg       in         24     recip_ratio, written when cfg_wr_en is high
//
// One angle pair is accepted every cycle while the queue has room; the
// front end updates its turn state in the cycle of acceptance.
// When nothing stalls, the queue hands an accepted pair on into the first of the four
// position pipeline registers and on through the rest to the output; the split
// partial products of the reciprocal multiply set that depth.
// The first pair after reset only primes the origin and gives no result.
// A stalled output holds the pipeline, then fills the queue, then drops tready.
module dual_encoder_multiturn_corexy #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // angle_a [11:0], angle_b [23:12]
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [dencxy_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // total_a [35:0], total_b [71:36], turns_a [95:72], turns_b [119:96],
  // motion_a [122:120], motion_b [125:123], pos_x [173:126], pos_y [221:174]
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [dencxy_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [dencxy_pkg::RECIP_BITS-1:0]     cfg_wr_data
);

  logic [dencxy_pkg::RECIP_BITS-1:0] recip_ratio;

  logic               q_push, q_full, q_pop, q_valid;
  dencxy_pkg::entry_t q_push_entry, q_pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      recip_ratio <= dencxy_pkg::RECIP_RESET;
    end else if (cfg_wr_en) begin
      recip_ratio <= cfg_wr_data;
    end
  end

  dencxy_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_push   (q_push),
    .q_entry  (q_push_entry),
    .q_full   (q_full)
  );

  dencxy_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .valid      (q_valid)
  );

  dencxy_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_pop_entry),
    .recip     (recip_ratio),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
